FILE: design/dtd_pkg.sv
// Shared types, constants and the month table for the date difference block.
package dtd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    // Wide enough for the ordinal of any 14-bit year.
    localparam int ORD_W   = 23;
    localparam int DBM_W   = 9;

    localparam logic [ORD_W-1:0]   DAYS_PER_YEAR = ORD_W'(365);
    localparam logic [MONTH_W-1:0] MONTH_JAN     = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB     = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC     = MONTH_W'(12);
    localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ORD_A = 4'b0010,
        ST_ORD_B = 4'b0100,
        ST_DIFF  = 4'b1000
    } dtd_state_t;

    typedef struct packed {
        logic load;
        logic calc_a;
        logic calc_b;
        logic finish;
    } dtd_cmd_t;

    // Days in the year before the first of the given month (1..12).
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/date_difference_days.sv
// Absolute day difference between two calendar dates (every fourth year leap).
// Pulse start while busy is low to hand over both dates; busy rises and the block
// runs in order: capture, ordinal of the first date, ordinal of the second date
// through the same multiply-add unit, then difference. done is high for exactly one
// cycle with day_count, both registered from the difference step; the receiver
// must take it then. busy falls with done, so a new start is taken in that same
// cycle. Counts above the 22-bit range saturate at all ones.
module date_difference_days (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dtd_pkg::DAY_W-1:0]     first_day,
    input  logic [dtd_pkg::MONTH_W-1:0]   first_month,
    input  logic [dtd_pkg::YEAR_W-1:0]    first_year,
    input  logic [dtd_pkg::DAY_W-1:0]     second_day,
    input  logic [dtd_pkg::MONTH_W-1:0]   second_month,
    input  logic [dtd_pkg::YEAR_W-1:0]    second_year,
    output logic                          done,
    output logic [dtd_pkg::COUNT_W-1:0]   day_count
);

    dtd_pkg::dtd_cmd_t cmd;

    dtd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    dtd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .first_day    (first_day),
        .first_month  (first_month),
        .first_year   (first_year),
        .second_day   (second_day),
        .second_month (second_month),
        .second_year  (second_year),
        .done         (done),
        .day_count    (day_count)
    );

endmodule

FILE: design/dtd_ctrl.sv
// Sequencing state machine for the date difference block.
module dtd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output dtd_pkg::dtd_cmd_t cmd
);

    dtd_pkg::dtd_state_t state_reg;
    dtd_pkg::dtd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            dtd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = dtd_pkg::ST_ORD_A;
                end
            end
            dtd_pkg::ST_ORD_A:
            begin
                cmd.calc_a = 1'b1;
                state_next = dtd_pkg::ST_ORD_B;
            end
            dtd_pkg::ST_ORD_B:
            begin
                cmd.calc_b = 1'b1;
                state_next = dtd_pkg::ST_DIFF;
            end
            dtd_pkg::ST_DIFF:
            begin
                cmd.finish = 1'b1;
                state_next = dtd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dtd_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != dtd_pkg::ST_IDLE);

endmodule

FILE: design/dtd_dp.sv
// Datapath: operand capture, shared day-ordinal unit, difference and saturation.
module dtd_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dtd_pkg::dtd_cmd_t             cmd,
    input  logic [dtd_pkg::DAY_W-1:0]     first_day,
    input  logic [dtd_pkg::MONTH_W-1:0]   first_month,
    input  logic [dtd_pkg::YEAR_W-1:0]    first_year,
    input  logic [dtd_pkg::DAY_W-1:0]     second_day,
    input  logic [dtd_pkg::MONTH_W-1:0]   second_month,
    input  logic [dtd_pkg::YEAR_W-1:0]    second_year,
    output logic                          done,
    output logic [dtd_pkg::COUNT_W-1:0]   day_count
);

    logic [dtd_pkg::DAY_W-1:0]   a_day_reg,   b_day_reg;
    logic [dtd_pkg::MONTH_W-1:0] a_month_reg, b_month_reg;
    logic [dtd_pkg::YEAR_W-1:0]  a_year_reg,  b_year_reg;
    logic [dtd_pkg::ORD_W-1:0]   ord_a_reg,   ord_b_reg;
    logic [dtd_pkg::COUNT_W-1:0] count_reg,   count_next;
    logic                        done_reg;

    logic [dtd_pkg::DAY_W-1:0]   op_day;
    logic [dtd_pkg::MONTH_W-1:0] op_month;
    logic [dtd_pkg::MONTH_W-1:0] op_month_c;
    logic [dtd_pkg::YEAR_W-1:0]  op_year;
    logic [dtd_pkg::YEAR_W:0]    leap_sum;
    logic [dtd_pkg::ORD_W-1:0]   ord_calc;
    logic [dtd_pkg::ORD_W-1:0]   diff;

    // Shared ordinal unit: pick the operand, clamp the month.
    assign op_day   = cmd.calc_b ? b_day_reg   : a_day_reg;
    assign op_month = cmd.calc_b ? b_month_reg : a_month_reg;
    assign op_year  = cmd.calc_b ? b_year_reg  : a_year_reg;

    always_comb
    begin
        if (op_month < dtd_pkg::MONTH_JAN)
        begin
            op_month_c = dtd_pkg::MONTH_JAN;
        end
        else if (op_month > dtd_pkg::MONTH_DEC)
        begin
            op_month_c = dtd_pkg::MONTH_DEC;
        end
        else
        begin
            op_month_c = op_month;
        end
    end

    // Leap days in years 0..y-1 is ceil(y/4).
    assign leap_sum = {1'b0, op_year} + (dtd_pkg::YEAR_W+1)'(3);

    always_comb
    begin
        ord_calc = dtd_pkg::ORD_W'(op_year) * dtd_pkg::DAYS_PER_YEAR
                 + dtd_pkg::ORD_W'(leap_sum[dtd_pkg::YEAR_W:2])
                 + dtd_pkg::ORD_W'(dtd_pkg::days_before_month(op_month_c))
                 + dtd_pkg::ORD_W'(op_day);
        if ((op_year[1:0] == 2'b00) && (op_month_c > dtd_pkg::MONTH_FEB))
        begin
            ord_calc = ord_calc + dtd_pkg::ORD_W'(1);
        end
    end

    assign diff = (ord_a_reg > ord_b_reg) ? (ord_a_reg - ord_b_reg)
                                          : (ord_b_reg - ord_a_reg);

    always_comb
    begin
        if (diff[dtd_pkg::ORD_W-1:dtd_pkg::COUNT_W] != '0)
        begin
            count_next = dtd_pkg::COUNT_MAX;
        end
        else
        begin
            count_next = diff[dtd_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_day_reg   <= first_day;
            a_month_reg <= first_month;
            a_year_reg  <= first_year;
            b_day_reg   <= second_day;
            b_month_reg <= second_month;
            b_year_reg  <= second_year;
        end
        if (cmd.calc_a)
        begin
            ord_a_reg <= ord_calc;
        end
        if (cmd.calc_b)
        begin
            ord_b_reg <= ord_calc;
        end
        if (cmd.finish)
        begin
            count_reg <= count_next;
        end
    end

    // Strobe the result beat for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    assign done      = done_reg;
    assign day_count = count_reg;

endmodule

FILE: design/dtd_chk.sv
// Port-level checker for the date difference block, bound to the top level.
module dtd_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted start");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result beat missing four cycles after start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    a_busy_ends: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (busy || done))
        else $error("busy dropped without a result beat");

endmodule

bind date_difference_days dtd_chk u_dtd_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
